>>> src/lru_record_buffer_lookup_macros.svh
// Assertion macros for the record buffer lookup block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef LRU_RECORD_BUFFER_LOOKUP_MACROS_SVH
`define LRU_RECORD_BUFFER_LOOKUP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lrb_pkg.sv
// Shared types and fixed field widths for the record buffer lookup block.
// No dependencies.
`timescale 1ns / 1ps

package lrb_pkg;

    localparam int LINE_NUMBER_W = 24;
    localparam int SLOT_OUT_W    = 4;

    typedef struct packed {
        logic capture;
        logic match;
        logic update;
    } lrb_cmd_t;

endpackage

>>> src/lrb_ctrl.sv
// Sequencer of the record buffer lookup: handshakes and step commands.
// Depends on lrb_pkg.
`timescale 1ns / 1ps

module lrb_ctrl
    import lrb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output lrb_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       can_load;
    logic       accept;

    assign can_load  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) || ((state_reg == ST_UPDATE) && can_load));
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.capture = accept;
        cmd.match   = (state_reg == ST_MATCH);
        cmd.update  = (state_reg == ST_UPDATE) && can_load;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (can_load)
                begin
                    state_next = accept ? ST_MATCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/lrb_datapath.sv
// Recency list, tag compare, move-to-front shift and result registers.
// Depends on lrb_pkg; driven by the commands of lrb_ctrl.
`timescale 1ns / 1ps

module lrb_datapath
    import lrb_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int LINE_BITS = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lrb_cmd_t                 cmd,
    input  logic [LINE_NUMBER_W-1:0] line_number,
    output logic                     hit,
    output logic [SLOT_OUT_W-1:0]    slot,
    output logic                     evicted,
    output logic [LINE_NUMBER_W-1:0] evicted_line
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [LINE_BITS-1:0]     tags_reg [DEPTH];
    logic [IDX_W-1:0]         slots_reg [DEPTH];
    logic [OCC_W-1:0]         occ_reg;
    logic [LINE_BITS-1:0]     tag_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     full_reg;

    logic [LINE_BITS+LINE_NUMBER_W-1:0] line_ext;
    logic                     found_next;
    logic [IDX_W-1:0]         idx_next;
    logic [IDX_W-1:0]         pos;
    logic [IDX_W-1:0]         slot_val;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;
    logic [LINE_BITS+LINE_NUMBER_W-1:0] victim_ext;

    logic                     hit_reg;
    logic [SLOT_OUT_W-1:0]    slot_reg;
    logic                     evicted_reg;
    logic [LINE_NUMBER_W-1:0] evicted_line_reg;

    assign line_ext = {{LINE_BITS{1'b0}}, line_number};

    // The entry nearest the front wins, so the scan runs from the back.
    always_comb
    begin
        found_next = 1'b0;
        idx_next   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if ((OCC_W'(i) < occ_reg) && (tags_reg[i] == tag_reg))
            begin
                found_next = 1'b1;
                idx_next   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (found_reg)
        begin
            pos      = idx_reg;
            slot_val = slots_reg[idx_reg];
        end
        else if (full_reg)
        begin
            pos      = IDX_W'(DEPTH - 1);
            slot_val = slots_reg[DEPTH-1];
        end
        else
        begin
            pos      = occ_reg[IDX_W-1:0];
            slot_val = occ_reg[IDX_W-1:0];
        end
    end

    assign slot_ext   = {{SLOT_OUT_W{1'b0}}, slot_val};
    assign victim_ext = {{LINE_NUMBER_W{1'b0}}, tags_reg[DEPTH-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_reg <= line_ext[LINE_BITS-1:0];
        end
        if (cmd.match)
        begin
            found_reg <= found_next;
            idx_reg   <= idx_next;
            full_reg  <= (occ_reg == OCC_W'(DEPTH));
        end
        if (cmd.update)
        begin
            for (int k = 1; k < DEPTH; k++)
            begin
                if (IDX_W'(k) <= pos)
                begin
                    tags_reg[k]  <= tags_reg[k-1];
                    slots_reg[k] <= slots_reg[k-1];
                end
            end
            tags_reg[0]      <= tag_reg;
            slots_reg[0]     <= slot_val;
            hit_reg          <= found_reg;
            slot_reg         <= slot_ext[SLOT_OUT_W-1:0];
            evicted_reg      <= !found_reg && full_reg;
            evicted_line_reg <= (!found_reg && full_reg) ?
                                victim_ext[LINE_NUMBER_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.update && !found_reg && !full_reg)
        begin
            occ_reg <= occ_reg + 1'b1;
        end
    end

    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign evicted      = evicted_reg;
    assign evicted_line = evicted_line_reg;

endmodule

>>> src/lru_record_buffer_lookup.sv
// An accepted line number is compared in the match step; the update step then does
// the move-to-front shift of the recency list and registers the result, waiting while
// the output is stalled. A new line is accepted only when idle or in the update step.
// Reset clears the occupancy count and the handshake state; the list
// contents are not cleared, as entries beyond the occupancy are never read.
`timescale 1ns / 1ps
`include "lru_record_buffer_lookup_macros.svh"

module lru_record_buffer_lookup
    import lrb_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int LINE_BITS = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [LINE_NUMBER_W-1:0] line_number,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic [SLOT_OUT_W-1:0]    slot,
    output logic                     evicted,
    output logic [LINE_NUMBER_W-1:0] evicted_line
);

    lrb_cmd_t cmd;

    lrb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lrb_datapath #(
        .DEPTH     (DEPTH),
        .LINE_BITS (LINE_BITS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .line_number  (line_number),
        .hit          (hit),
        .slot         (slot),
        .evicted      (evicted),
        .evicted_line (evicted_line)
    );

    `LRB_ASSERT_SAME(a_hit_not_evict, out_valid, !(hit && evicted), "hit beat also evicts")
    `LRB_ASSERT_SAME(a_no_victim_line, out_valid && !evicted, evicted_line == '0, "stray victim")
    `LRB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted too early")
    `LRB_ASSERT_NEXT(a_result_follows, cmd.match, cmd.update || in_stall, "result step lost")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the LRU record buffer lookup block.
// Needs lrb_pkg and lru_record_buffer_lookup; predicts each result from its own copy
// of the recency list and compares every output beat field by field.
`timescale 1ns / 1ps

module tb_top;
    import lrb_pkg::*;

    localparam int LRU_DEPTH     = 16;
    localparam int POOL_SIZE     = 32;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        logic                     hit;
        logic [SLOT_OUT_W-1:0]    slot;
        logic                     evicted;
        logic [LINE_NUMBER_W-1:0] evicted_line;
    } lookup_result_t;

    typedef struct packed {
        logic           fixed;
        lookup_result_t result;
    } line_beat_t;

    typedef struct packed {
        logic [LINE_NUMBER_W-1:0] line;
        logic                     fixed;
        lookup_result_t           result;
    } stim_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } stall_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [LINE_NUMBER_W-1:0] line_number = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     hit;
    logic [SLOT_OUT_W-1:0]    slot;
    logic                     evicted;
    logic [LINE_NUMBER_W-1:0] evicted_line;

    logic [LINE_NUMBER_W-1:0] lru_tags [LRU_DEPTH];
    logic [SLOT_OUT_W-1:0]    lru_slots [LRU_DEPTH];
    int                       lru_count = 0;

    lookup_result_t pending_results [$];
    line_beat_t     line_beats [$];
    stim_row_t      directed_rows [DIRECTED_ROWS];

    int fail_count   = 0;
    int result_count = 0;
    int hit_count    = 0;
    int miss_count   = 0;
    int evict_count  = 0;
    int burst_left   = 0;

    stall_mode_t stall_mode    = STALL_NONE;
    int          stall_left    = 0;
    logic [7:0]  stall_pattern = 8'h00;

    lru_record_buffer_lookup #(
        .DEPTH     (LRU_DEPTH),
        .LINE_BITS (LINE_NUMBER_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .line_number  (line_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .slot         (slot),
        .evicted      (evicted),
        .evicted_line (evicted_line)
    );

    always #2 clk = ~clk;

    function automatic lookup_result_t predict_lookup(input logic [LINE_NUMBER_W-1:0] line);
        lookup_result_t        res;
        int                    found;
        int                    last;
        logic [SLOT_OUT_W-1:0] home;
        res   = '0;
        found = -1;
        for (int i = 0; i < lru_count; i++)
        begin
            if (found < 0 && lru_tags[i] == line)
                found = i;
        end
        if (found >= 0)
        begin
            res.hit = 1'b1;
            home    = lru_slots[found];
            last    = found;
        end
        else if (lru_count >= LRU_DEPTH)
        begin
            res.evicted      = 1'b1;
            res.evicted_line = lru_tags[LRU_DEPTH-1];
            home             = lru_slots[LRU_DEPTH-1];
            last             = LRU_DEPTH - 1;
        end
        else
        begin
            home      = SLOT_OUT_W'(lru_count);
            last      = lru_count;
            lru_count = lru_count + 1;
        end
        for (int k = last; k > 0; k--)
        begin
            lru_tags[k]  = lru_tags[k-1];
            lru_slots[k] = lru_slots[k-1];
        end
        lru_tags[0]  = line;
        lru_slots[0] = home;
        res.slot     = home;
        return res;
    endfunction

    task automatic send_line(input logic [LINE_NUMBER_W-1:0] line, input logic fixed,
                             input lookup_result_t res);
        line_beat_t beat;
        beat.fixed  = fixed;
        beat.result = res;
        line_beats.push_back(beat);
        in_valid    <= 1'b1;
        line_number <= line;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pace_sender();
        burst_left = burst_left - 1;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode    <= stall_mode_t'($urandom_range(0, 3));
                stall_left    <= $urandom_range(40, 300);
                stall_pattern <= 8'($urandom);
            end
            else
            begin
                stall_left    <= stall_left - 1;
                stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= stall_pattern[0];
            endcase
        end
    end

    // Output beats are retired before the input beat of the same edge is predicted.
    always @(posedge clk)
    begin
        line_beat_t     beat;
        lookup_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_count = result_count + 1;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no expectation waiting, hit %0b slot %0h",
                             $time, hit, slot);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                        fail_count = fail_count + 1;
                    end
                    if (slot !== want.slot)
                    begin
                        $display("%0t: slot expected %0h actual %0h", $time, want.slot, slot);
                        fail_count = fail_count + 1;
                    end
                    if (evicted !== want.evicted)
                    begin
                        $display("%0t: evicted expected %0b actual %0b",
                                 $time, want.evicted, evicted);
                        fail_count = fail_count + 1;
                    end
                    if (evicted_line !== want.evicted_line)
                    begin
                        $display("%0t: evicted_line expected %06h actual %06h",
                                 $time, want.evicted_line, evicted_line);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                beat = (line_beats.size() != 0) ? line_beats.pop_front() : '0;
                want = predict_lookup(line_number);
                if (want.hit)
                    hit_count = hit_count + 1;
                else
                    miss_count = miss_count + 1;
                if (want.evicted)
                    evict_count = evict_count + 1;
                if (beat.fixed)
                    want = beat.result;
                pending_results.push_back(want);
            end
        end
    end

    initial
    begin
        logic [LINE_NUMBER_W-1:0] line_pool [POOL_SIZE];
        logic [LINE_NUMBER_W-1:0] line;
        logic [LINE_NUMBER_W-1:0] last_line;
        int                       window;
        int                       pick;

        directed_rows = '{
            '{24'h000000, 1'b1, '{1'b0, 4'd0, 1'b0, 24'h000000}},
            '{24'hFFFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 24'h000000}},
            '{24'h000000, 1'b1, '{1'b1, 4'd0, 1'b0, 24'h000000}},
            '{24'h000000, 1'b1, '{1'b1, 4'd0, 1'b0, 24'h000000}},
            '{24'h000001, 1'b0, '0},
            '{24'h800000, 1'b0, '0},
            '{24'h555555, 1'b0, '0},
            '{24'hAAAAAA, 1'b0, '0},
            '{24'h7FFFFF, 1'b0, '0},
            '{24'hFFFFFE, 1'b0, '0},
            '{24'h123456, 1'b0, '0},
            '{24'h654321, 1'b0, '0},
            '{24'h0F0F0F, 1'b0, '0},
            '{24'hF0F0F0, 1'b0, '0},
            '{24'h00FF00, 1'b0, '0},
            '{24'hFF00FF, 1'b0, '0},
            '{24'h000100, 1'b0, '0},
            '{24'h010000, 1'b0, '0},
            '{24'hFFFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 24'h000000}},
            '{24'h333333, 1'b1, '{1'b0, 4'd0, 1'b1, 24'h000000}},
            '{24'h000000, 1'b1, '{1'b0, 4'd2, 1'b1, 24'h000001}},
            '{24'h800000, 1'b1, '{1'b1, 4'd3, 1'b0, 24'h000000}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 20);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_line(directed_rows[r].line, directed_rows[r].fixed, directed_rows[r].result);
            pace_sender();
        end

        for (int p = 0; p < POOL_SIZE; p++)
            line_pool[p] = LINE_NUMBER_W'($urandom);
        window    = $urandom_range(4, 28);
        last_line = '0;

        // Mostly a shifting working set around the list depth, so hits, refills
        // and evictions all stay frequent; the rest is fresh lines, repeats of the last line or corner lines.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 99)
                window = $urandom_range(2, POOL_SIZE);
            pick = $urandom_range(0, 99);
            if (pick < 80)
                line = line_pool[$urandom_range(0, window - 1)];
            else if (pick < 88)
            begin
                line = LINE_NUMBER_W'($urandom);
                line_pool[$urandom_range(0, POOL_SIZE - 1)] = line;
            end
            else if (pick < 93)
                line = last_line;
            else if (pick < 96)
                line = LINE_NUMBER_W'($urandom);
            else if (pick < 98)
                line = '0;
            else
                line = '1;
            send_line(line, 1'b0, '0);
            last_line = line;
            pace_sender();
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0 || line_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Lookups: %0d results checked, %0d hits, %0d misses, %0d evictions.",
                 result_count, hit_count, miss_count, evict_count);
        $display("Mismatches found: %0d.", fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/lrb_pkg.sv
src/lrb_ctrl.sv
src/lrb_datapath.sv
src/lru_record_buffer_lookup.sv
tb/tb_top.sv
